### design/voxel_ray_traversal_assert.svh
// Assertion macros for the voxel ray traversal checker
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define VRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voxel_ray_traversal check failed");

// antecedent holds -> consequent in the next cycle
`define VRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voxel_ray_traversal check failed");

`endif

### design/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int T_WIDTH         = 32;
  localparam int T_FRAC          = T_WIDTH - 8;
  localparam int DIR_FRAC        = 14;
  localparam int NUM_BITS        = DIR_FRAC + T_FRAC + 1;   // dividend 2^(DIR_FRAC+T_FRAC)
  localparam int START_W         = 24;
  localparam int DIR_W           = 16;
  localparam int MAG_W           = DIR_W + 1;
  localparam int REACH_W         = 7;
  localparam int DEN_W           = MAG_W + REACH_W;
  localparam int VOX_W           = 17;
  localparam int FRAC_W          = COORD_FRAC_BITS + 1;
  localparam int PROD_W          = T_WIDTH + FRAC_W;
  localparam int CNT_LAST        = NUM_BITS + 2;
  localparam int CNT_W           = $clog2(CNT_LAST + 1);
  localparam int IN_DATA_W       = 128;
  localparam int OUT_DATA_W      = 64;
  localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(5);
  localparam logic [T_WIDTH-1:0] T_MAX = {T_WIDTH{1'b1}};
  localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(1) << T_FRAC;

  typedef enum logic [1:0] {
    ST_PROBE = 2'd0,
    ST_END   = 2'd1,
    ST_HIT   = 2'd2,
    ST_NORAY = 2'd3
  } status_t;

  localparam logic FUNC_RAY = 1'b0;

  typedef struct packed {
    logic ray;       // load a new ray
    logic ans;       // latch the solid answer
    logic div_run;   // advance the set-up sequencer
    logic step;      // evaluate the answer
    logic out_load;  // load the output register
  } vrt_cmd_t;

  typedef struct packed {
    logic div_done;
  } vrt_sts_t;

endpackage

### design/vrt_datapath.sv
// ----------------------------------------------------------------------------
// vrt_datapath
// Ray state, bit-serial t-delta divider, crossing set-up and grid step.
// ----------------------------------------------------------------------------
module vrt_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wen,
  input  logic [vrt_pkg::REACH_W-1:0]       cfg_wdata,
  input  logic [vrt_pkg::IN_DATA_W-1:0]     in_tdata,
  input  vrt_pkg::vrt_cmd_t                 cmd,
  output vrt_pkg::vrt_sts_t                 sts,
  output logic [vrt_pkg::OUT_DATA_W-1:0]    out_data,
  output logic [1:0]                        out_user
);

  localparam int CFB = vrt_pkg::COORD_FRAC_BITS;
  localparam int TW  = vrt_pkg::T_WIDTH;
  localparam int NB  = vrt_pkg::NUM_BITS;
  localparam int DW  = vrt_pkg::DEN_W;
  localparam int VW  = vrt_pkg::VOX_W;

  logic [vrt_pkg::REACH_W-1:0] reach_r;
  logic                        active_r;
  logic                        solid_r;
  logic                        noray_r;
  vrt_pkg::status_t            st_r;
  logic [VW-1:0]               pos_r   [3];
  logic signed [1:0]           sign_r  [3];
  logic signed [1:0]           norm_r  [3];
  logic [TW-1:0]               cross_r [3];
  logic [TW-1:0]               delta_r [3];
  logic [vrt_pkg::MAG_W-1:0]   mag_r   [3];
  logic [vrt_pkg::FRAC_W-1:0]  frac_r  [3];
  logic [vrt_pkg::CNT_W-1:0]   cnt_r;
  logic [1:0]                  axis_r;
  logic [DW-1:0]               den_r;
  logic [DW-1:0]               rem_r;
  logic [NB-1:0]               q_r;
  logic [TW-1:0]               qs_r;
  logic [vrt_pkg::PROD_W-1:0]  prod_r;
  logic [vrt_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0]                  out_user_r;

  logic signed [vrt_pkg::START_W-1:0] st_in [3];
  logic signed [vrt_pkg::DIR_W-1:0]   dir_in [3];
  logic [DW:0]                 rem2;
  logic [TW-1:0]               qs;
  logic [1:0]                  ax;
  logic [TW:0]                 csum;
  logic [TW-1:0]               cnew [3];
  logic [VW-1:0]               pnew;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      st_in[a]  = in_tdata[a*vrt_pkg::START_W +: vrt_pkg::START_W];
      dir_in[a] = in_tdata[3*vrt_pkg::START_W + a*vrt_pkg::DIR_W +: vrt_pkg::DIR_W];
    end
  end

  assign rem2 = {rem_r, (cnt_r == vrt_pkg::CNT_W'(1))};
  assign qs   = (q_r[NB-1:TW] != '0) ? vrt_pkg::T_MAX : q_r[TW-1:0];

  // smallest crossing, ties to z then y
  always_comb begin
    if (cross_r[0] < cross_r[1]) begin
      ax = (cross_r[0] < cross_r[2]) ? 2'd0 : 2'd2;
    end else begin
      ax = (cross_r[1] < cross_r[2]) ? 2'd1 : 2'd2;
    end
    csum = {1'b0, cross_r[ax]} + {1'b0, delta_r[ax]};
    pnew = pos_r[ax] + {{(VW-2){sign_r[ax][1]}}, sign_r[ax]};
    for (int a = 0; a < 3; a++) begin
      cnew[a] = cross_r[a];
    end
    cnew[ax] = csum[TW] ? vrt_pkg::T_MAX : csum[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r  <= vrt_pkg::REACH_RESET;
      active_r <= 1'b0;
      noray_r  <= 1'b0;
      st_r     <= vrt_pkg::ST_PROBE;
      cnt_r    <= '0;
      axis_r   <= '0;
      for (int a = 0; a < 3; a++) begin
        pos_r[a]   <= '0;
        sign_r[a]  <= '0;
        norm_r[a]  <= '0;
        cross_r[a] <= '0;
        delta_r[a] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        reach_r <= cfg_wdata;
      end
      if (cmd.ray) begin
        for (int a = 0; a < 3; a++) begin
          logic signed [vrt_pkg::START_W-1:0] sh;
          sh = st_in[a] >>> CFB;
          pos_r[a]  <= sh[VW-1:0];
          sign_r[a] <= (dir_in[a] > 0) ? 2'sd1 : ((dir_in[a] < 0) ? -2'sd1 : 2'sd0);
          norm_r[a] <= '0;
          mag_r[a]  <= dir_in[a][vrt_pkg::DIR_W-1]
                       ? vrt_pkg::MAG_W'(-{dir_in[a][vrt_pkg::DIR_W-1], dir_in[a]})
                       : vrt_pkg::MAG_W'(dir_in[a]);
          frac_r[a] <= (dir_in[a] > 0)
                       ? vrt_pkg::FRAC_W'((vrt_pkg::FRAC_W'(1) << CFB)
                                          - {1'b0, st_in[a][CFB-1:0]})
                       : {1'b0, st_in[a][CFB-1:0]};
        end
        if (dir_in[0] == '0 && dir_in[1] == '0 && dir_in[2] == '0) begin
          active_r <= 1'b0;
          st_r     <= vrt_pkg::ST_END;
        end else begin
          active_r <= 1'b1;
          st_r     <= vrt_pkg::ST_PROBE;
        end
        noray_r <= 1'b0;
        cnt_r   <= '0;
        axis_r  <= '0;
      end
      if (cmd.div_run) begin
        if (cnt_r == vrt_pkg::CNT_W'(vrt_pkg::CNT_LAST)) begin
          cnt_r  <= '0;
          axis_r <= axis_r + 2'd1;
          if (den_r == '0) begin
            delta_r[axis_r] <= vrt_pkg::T_MAX;
            cross_r[axis_r] <= vrt_pkg::T_MAX;
          end else begin
            delta_r[axis_r] <= qs_r;
            cross_r[axis_r] <= prod_r[vrt_pkg::PROD_W-1] ? vrt_pkg::T_MAX
                                                         : prod_r[TW+CFB-1:CFB];
          end
        end else begin
          cnt_r <= cnt_r + vrt_pkg::CNT_W'(1);
        end
      end
      if (cmd.step) begin
        if (!active_r) begin
          noray_r <= 1'b1;
          st_r    <= vrt_pkg::ST_NORAY;
        end else if (solid_r) begin
          active_r <= 1'b0;
          st_r     <= vrt_pkg::ST_HIT;
        end else begin
          pos_r[ax] <= pnew;
          for (int a = 0; a < 3; a++) begin
            cross_r[a] <= cnew[a];
            norm_r[a]  <= (ax == 2'(a)) ? -sign_r[a] : 2'sd0;
          end
          if (cnew[0] > vrt_pkg::T_ONE && cnew[1] > vrt_pkg::T_ONE
              && cnew[2] > vrt_pkg::T_ONE) begin
            active_r <= 1'b0;
            st_r     <= vrt_pkg::ST_END;
          end else begin
            st_r     <= vrt_pkg::ST_PROBE;
          end
        end
      end
    end
  end

  // divider, crossing multiply, solid latch and output register, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.ans) begin
      solid_r <= in_tdata[3*vrt_pkg::START_W + 3*vrt_pkg::DIR_W];
    end
    if (cmd.div_run) begin
      if (cnt_r == '0) begin
        den_r <= mag_r[axis_r] * reach_r;
        rem_r <= '0;
        q_r   <= '0;
      end else if (cnt_r <= vrt_pkg::CNT_W'(NB)) begin
        if (rem2 >= {1'b0, den_r}) begin
          rem_r <= DW'(rem2 - {1'b0, den_r});
          q_r   <= {q_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= rem2[DW-1:0];
          q_r   <= {q_r[NB-2:0], 1'b0};
        end
      end else if (cnt_r == vrt_pkg::CNT_W'(NB + 1)) begin
        qs_r   <= qs;
        prod_r <= qs * frac_r[axis_r];
      end
    end
    if (cmd.out_load) begin
      if (noray_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= vrt_pkg::OUT_DATA_W'({norm_r[2], norm_r[1], norm_r[0],
                                             pos_r[2], pos_r[1], pos_r[0]});
      end
      out_user_r <= st_r;
    end
  end

  assign sts.div_done = cmd.div_run && (axis_r == 2'd2)
                        && (cnt_r == vrt_pkg::CNT_W'(vrt_pkg::CNT_LAST));
  assign out_data = out_data_r;
  assign out_user = out_user_r;

endmodule

### design/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer for ray set-up, step evaluation and output handshake.
// ----------------------------------------------------------------------------
module vrt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_func,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  vrt_pkg::vrt_sts_t sts,
  output vrt_pkg::vrt_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_STEP = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_func == vrt_pkg::FUNC_RAY) begin
            cmd.ray   = 1'b1;
            state_nxt = S_DIV;
          end else begin
            cmd.ans   = 1'b1;
            state_nxt = S_STEP;
          end
        end
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

### design/voxel_ray_traversal.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// Grid walk of a ray through unit voxels, one probe per answer item.
// ----------------------------------------------------------------------------
//  channel | ports      | tdata (low bit up)                         | tuser
//  in      | in_t*      | start_x,y,z, dir_x,y,z, solid, zero pad    | func
//  out     | out_t*     | voxel_x,y,z, normal_x,y,z, zero pad        | status
//  cfg     | cfg_wen    | cfg_wdata = reach_distance                 | -
//
// An answer item goes from accept through the step state to the output
// load, which waits while the output register is full. A ray item runs the
// bit-serial divider per axis: set-up, NUM_BITS steps, multiply, write-back.
// Reset (rst_n low, synchronous) clears the ray and sets reach to 5.
// A new item is taken while the previous result still waits on out_tready;
// its result is held until the output register frees.
module voxel_ray_traversal (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wen,
  input  logic [vrt_pkg::REACH_W-1:0]       cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vrt_pkg::IN_DATA_W-1:0]     in_tdata,   // start_x,y,z, dir_x,y,z, solid
  input  logic                              in_tuser,   // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vrt_pkg::OUT_DATA_W-1:0]    out_tdata,  // voxel_x,y,z, normal_x,y,z
  output logic [1:0]                        out_tuser   // status
);

  vrt_pkg::vrt_cmd_t cmd;
  vrt_pkg::vrt_sts_t sts;

  vrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  vrt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

### design/vrt_checker.sv
// ----------------------------------------------------------------------------
// vrt_checker
// Port-level checks for voxel_ray_traversal, bound to the top level.
// ----------------------------------------------------------------------------
`include "voxel_ray_traversal_assert.svh"

module vrt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [vrt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser
);

  `VRT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `VRT_ASSERT_NOW(a_noray_zero, out_tvalid && out_tuser == vrt_pkg::ST_NORAY, out_tdata == '0)
  `VRT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `VRT_ASSERT_NOW(a_normal_range, out_tvalid, out_tdata[52:51] != 2'b10 && out_tdata[54:53] != 2'b10 && out_tdata[56:55] != 2'b10)
  `VRT_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[63:57] == '0)

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/sv/tb_voxel_ray_traversal.sv
// ----------------------------------------------------------------------------
// tb_voxel_ray_traversal
// Self-checking bench: random ray and answer items, grid walk predicted here.
// ----------------------------------------------------------------------------
module tb_voxel_ray_traversal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      TW      = 32;
  localparam int      TFR     = TW - 8;
  localparam longint  TSAT    = (64'd1 << TW) - 1;
  localparam longint  TUNIT   = 64'd1 << TFR;
  localparam int      WDOG    = 20000;

  typedef struct {
    logic        func;
    logic [23:0] sx, sy, sz;
    logic [15:0] dx, dy, dz;
    logic        solid;
  } ray_item_t;

  typedef struct packed {
    logic [16:0]      vx, vy, vz;
    logic [1:0]       nx, ny, nz;
    vrt_pkg::status_t st;
  } voxel_res_t;

  logic clk = 0, rst_n = 0;
  logic cfg_wen = 0;
  logic [vrt_pkg::REACH_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 0, in_tready;
  logic [vrt_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid, out_tready = 0;
  logic [vrt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  voxel_ray_traversal i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  longint     reach = 5;
  logic       walking;
  logic [16:0] vpos[3];
  int         sgn[3];
  longint     tnext[3], tdelta[3];
  int         nrm[3];

  ray_item_t  pending_items[$];
  voxel_res_t expected_voxels[$];
  int errors = 0, idle_cycles = 0;
  bit hold_out = 0;

  function automatic logic [1:0] nbits(int n);
    return n < 0 ? 2'b11 : 2'(n);
  endfunction

  function automatic voxel_res_t voxel_out(vrt_pkg::status_t st, bit blank);
    voxel_res_t r;
    r.vx = blank ? '0 : vpos[0];
    r.vy = blank ? '0 : vpos[1];
    r.vz = blank ? '0 : vpos[2];
    r.nx = blank ? '0 : nbits(nrm[0]);
    r.ny = blank ? '0 : nbits(nrm[1]);
    r.nz = blank ? '0 : nbits(nrm[2]);
    r.st = st;
    return r;
  endfunction

  function automatic void setup_axis(int a, logic [23:0] s, logic [15:0] d);
    longint dv, mag, den, q, fr, t;
    dv = longint'($signed(d));
    mag = dv < 0 ? -dv : dv;
    den = mag * reach;
    vpos[a] = 17'($signed(s) >>> 8);
    sgn[a] = dv > 0 ? 1 : (dv < 0 ? -1 : 0);
    if (den == 0) begin
      tdelta[a] = TSAT;
      tnext[a] = TSAT;
    end else begin
      q = (64'd1 << (14 + TFR)) / den;
      if (q > TSAT) q = TSAT;
      tdelta[a] = q;
      fr = sgn[a] > 0 ? 256 - longint'(s[7:0]) : longint'(s[7:0]);
      t = (q * fr) >> 8;
      tnext[a] = t > TSAT ? TSAT : t;
    end
  endfunction

  function automatic voxel_res_t walk_step(ray_item_t it);
    int ax;
    longint sm;
    if (it.func == vrt_pkg::FUNC_RAY) begin
      setup_axis(0, it.sx, it.dx);
      setup_axis(1, it.sy, it.dy);
      setup_axis(2, it.sz, it.dz);
      for (int a = 0; a < 3; a++) nrm[a] = 0;
      walking = !(sgn[0] == 0 && sgn[1] == 0 && sgn[2] == 0);
      return voxel_out(walking ? vrt_pkg::ST_PROBE : vrt_pkg::ST_END, 0);
    end
    if (!walking) return voxel_out(vrt_pkg::ST_NORAY, 1);
    if (it.solid) begin
      walking = 0;
      return voxel_out(vrt_pkg::ST_HIT, 0);
    end
    if (tnext[0] < tnext[1]) ax = tnext[0] < tnext[2] ? 0 : 2;
    else ax = tnext[1] < tnext[2] ? 1 : 2;
    vpos[ax] = vpos[ax] + 17'(sgn[ax]);
    sm = tnext[ax] + tdelta[ax];
    tnext[ax] = sm > TSAT ? TSAT : sm;
    for (int a = 0; a < 3; a++) nrm[a] = 0;
    nrm[ax] = -sgn[ax];
    if (tnext[0] > TUNIT && tnext[1] > TUNIT && tnext[2] > TUNIT) begin
      walking = 0;
      return voxel_out(vrt_pkg::ST_END, 0);
    end
    return voxel_out(vrt_pkg::ST_PROBE, 0);
  endfunction

  function automatic ray_item_t mk_ray(logic [23:0] x, y, z, logic [15:0] a, b, c);
    ray_item_t it;
    it = '{vrt_pkg::FUNC_RAY, x, y, z, a, b, c, 1'b0};
    return it;
  endfunction

  function automatic ray_item_t mk_answer(logic solid);
    ray_item_t it;
    it = '{1'b1, 24'($urandom), 24'($urandom), 24'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom), solid};
    return it;
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'($urandom);   // out of range, used as given
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // driver
  ray_item_t cur;
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_voxels.push_back(walk_step(cur));
        gap = $urandom_range(0, 10);
      end
      if ((!in_tvalid || in_tready)) begin
        if (gap > 0 || pending_items.size() == 0) begin
          if (gap > 0) gap--;
          in_tvalid <= 0;
        end else begin
          cur = pending_items.pop_front();
          in_tvalid <= 1;
          in_tuser <= cur.func;
          in_tdata <= {7'd0, cur.solid, cur.dz, cur.dy, cur.dx, cur.sz, cur.sy, cur.sx};
        end
      end
    end
  end

  // monitor
  int ostall = 0;
  voxel_res_t got, want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        idle_cycles <= 0;
        got.vx = out_tdata[16:0];
        got.vy = out_tdata[33:17];
        got.vz = out_tdata[50:34];
        got.nx = out_tdata[52:51];
        got.ny = out_tdata[54:53];
        got.nz = out_tdata[56:55];
        got.st = vrt_pkg::status_t'(out_tuser);
        if (expected_voxels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected voxel item %p", got);
        end else begin
          want = expected_voxels.pop_front();
          if (got != want || out_tdata[63:57] != 0) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
        ostall = $urandom_range(0, 10);
      end else if (in_tvalid && in_tready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (ostall > 0 && !(out_tvalid && out_tready)) ostall--;
      out_tready <= !hold_out && (ostall == 0 || $urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk)
    if (idle_cycles >= WDOG) begin
      $display("tb_voxel_ray_traversal NOT OK");
      $finish;
    end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_tvalid || expected_voxels.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reach(logic [vrt_pkg::REACH_W-1:0] v);
    @(posedge clk);
    cfg_wen <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 0;
    reach = v;
  endtask

  // one ray with a random walk of answers, mostly not solid
  task automatic queue_walk(int steps);
    pending_items.push_back(mk_ray(24'($urandom), 24'($urandom), 24'($urandom),
                                   rand_dir(), rand_dir(), rand_dir()));
    for (int i = 0; i < steps; i++)
      pending_items.push_back(mk_answer($urandom_range(0, 15) == 0));
  endtask

  initial begin
    logic [vrt_pkg::REACH_W-1:0] reach_set[5];
    reach_set = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // directed: answer with no ray, zero direction, extremes, ties, hit
    pending_items.push_back(mk_answer(0));
    pending_items.push_back(mk_ray(24'h7FFFFF, 24'h800000, 24'h000080,
                                   16'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_answer(0));
    pending_items.push_back(mk_ray(24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                                   16'sd16384, -16'sd16384, 16'sd16384));
    repeat (8) pending_items.push_back(mk_answer(0));
    pending_items.push_back(mk_ray(24'h000080, 24'h000080, 24'h000080,
                                   16'sd100, 16'sd100, 16'sd100));
    repeat (3) pending_items.push_back(mk_answer(0));
    pending_items.push_back(mk_answer(1));
    pending_items.push_back(mk_answer(1));
    pending_items.push_back(mk_ray(24'h000000, 24'h123456, 24'hABCDEF,
                                   16'hFFFF, 16'h8000, 16'h7FFF));
    pending_items.push_back(mk_ray(24'h000010, 24'd0, 24'd0, 16'sd1, 16'd0, 16'd0));
    pending_items.push_back(mk_answer(0));
    pending_items.push_back(mk_answer(0));
    wait_drained();
    // long receiver hold-off while the sender keeps offering
    hold_out = 1;
    queue_walk(20);
    repeat (300) @(posedge clk);
    hold_out = 0;
    wait_drained();
    foreach (reach_set[k]) begin
      write_reach(reach_set[k]);
      for (int n = 0; n < 200; ) begin
        int s;
        s = $urandom_range(0, 12);
        queue_walk(s);
        n += s + 1;
        if ($urandom_range(0, 9) == 0) pending_items.push_back(mk_answer(1'($urandom)));
      end
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_voxel_ray_traversal OK");
    else $display("tb_voxel_ray_traversal NOT OK");
    $finish;
  end
endmodule
